/* hw/rtl/vpvbw_pkg.sv */
// shared types, constants and helpers for the volume bucket window block
`default_nettype none

package vpvbw_pkg;

    localparam int QTY_W     = 32;
    localparam int VOL_W     = QTY_W + 1;
    localparam int TOT_W     = VOL_W + 1;
    localparam int WIN_W     = 7;
    localparam int Q_W       = 17;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int STEP_CNT_W = 5;

    localparam logic [Q_W-1:0]    Q_ONE            = 17'h10000;
    localparam logic [DATA_W-1:0] BKT_LIMIT_RST    = 32'd1000000;
    localparam logic [WIN_W-1:0]  WINDOW_RST       = 7'd50;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_BKT_LIMIT      = 1'b0;
    localparam reg_idx_t REG_WINDOW_BUCKETS = 1'b1;

    typedef struct packed {
        logic [QTY_W-1:0] qty;
        logic             is_buy;
    } trade_t;

    typedef struct packed {
        logic [Q_W-1:0]   vpin_q16;
        logic             bucket_closed;
        logic [WIN_W-1:0] buckets_held;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EVICT,
        S_SUB,
        S_ADD,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    function automatic logic [VOL_W-1:0] abs_diff(input logic [VOL_W-1:0] a,
                                                  input logic [VOL_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vpvbw_div.sv */
// serial restoring divider giving floor(num * 65536 / den), num <= den
`default_nettype none

module vpvbw_div
    import vpvbw_pkg::*;
#(
    parameter int W = 40
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [W-1:0]   num,
    input  wire logic [W-1:0]   den,
    output logic                done,
    output logic [Q_W-1:0]      quot
);

    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;
    logic                  done_reg;
    logic [W:0]            rem_reg;
    logic [W:0]            rem_next;
    logic [Q_W-1:0]        quot_reg;
    logic [W:0]            trial;
    logic [W:0]            den_ext;
    logic                  ge;

    always_comb
    begin
        den_ext  = {1'b0, den};
        trial    = (cnt_reg == STEP_CNT_W'(Q_W)) ? rem_reg : {rem_reg[W-1:0], 1'b0};
        ge       = (trial >= den_ext);
        rem_next = ge ? (trial - den_ext) : trial;
        cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= STEP_CNT_W'(Q_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_next;
            done_reg <= (cnt_next == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[Q_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = (quot_reg > Q_ONE) ? Q_ONE : quot_reg;

endmodule

`default_nettype wire

/* hw/rtl/vpin_volume_bucket_window_top.sv */
// top level of the volume-bucketed vpin window
//
// trade channel (trade_valid/trade_ready/trade) carries one trade: quantity
// and aggressor side. result channel (result_valid/result_ready/result)
// returns one transaction per trade: vpin in q1.16, a bucket-closed flag
// and the number of buckets held in the window.
// one trade is worked at a time. a trade that leaves the bucket open goes
// from acceptance through the check and the 17-step serial divider for the
// q16 ratio to the result; one that closes a bucket also passes the ring
// write and eviction, the subtract and the add into the window sums. with
// the window empty the divider is skipped.
// the next trade can be taken in the cycle after the result loads.
// the ring of completed buckets lives in one synchronous memory of
// MAX_BUCKETS entries; an entry's read data is used only once it has been written.
// a stalled result waits in the output register while the next trade is
// taken and worked; that trade's result is loaded once the register frees.
// reset clears the open bucket, the window and its sums and loads a bucket
// limit of 1000000 and a window of 50 buckets; no clearing pass is needed.
// writing window_buckets empties the window and keeps the open bucket.
`default_nettype none

module vpin_volume_bucket_window_top
    import vpvbw_pkg::*;
#(
    parameter int MAX_BUCKETS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  wire logic              trade_valid,
    output logic                   trade_ready,
    input  wire trade_t            trade,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output result_t                result
);

    localparam int CAP   = (MAX_BUCKETS > 127) ? 127 : MAX_BUCKETS;
    localparam int IDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SUM_W = TOT_W + $clog2(CAP);
    localparam logic [WIN_W-1:0] CAP_N = WIN_W'(CAP);

    state_t state_reg;
    state_t state_next;

    logic [DATA_W-1:0] bkt_limit_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [VOL_W-1:0]  open_buy_reg;
    logic [VOL_W-1:0]  open_sell_reg;
    logic [WIN_W-1:0]  oldest_reg;
    logic [WIN_W-1:0]  filled_reg;
    logic [SUM_W-1:0]  abs_sum_reg;
    logic [SUM_W-1:0]  vol_sum_reg;
    logic [WIN_W-1:0]  slot_reg;
    logic              full_reg;
    logic              closing_reg;
    logic [VOL_W-1:0]  old_abs_reg;
    logic [TOT_W-1:0]  old_tot_reg;
    logic [VOL_W-1:0]  new_abs_reg;
    logic [TOT_W-1:0]  new_tot_reg;
    logic [Q_W-1:0]    vpin_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    logic [2*VOL_W-1:0] ring_mem [MAX_BUCKETS];
    logic [2*VOL_W-1:0] rd_data_reg;
    logic [VOL_W-1:0]   rd_buy;
    logic [VOL_W-1:0]   rd_sell;

    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic [WIN_W-1:0]  eff_n;
    logic [DATA_W-1:0] limit;
    logic [TOT_W-1:0]  open_total;
    logic [WIN_W:0]    slot_sum;
    logic [WIN_W:0]    slot_wrap;
    logic [WIN_W-1:0]  slot_calc;
    logic              full_calc;
    logic [WIN_W:0]    slot_inc;
    logic [VOL_W-1:0]  qty_ext;
    logic              trade_acc;
    logic              out_free;
    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_quot;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_BKT_LIMIT:      prdata = bkt_limit_reg;
            REG_WINDOW_BUCKETS: prdata = DATA_W'(window_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkt_limit_reg <= BKT_LIMIT_RST;
            window_reg    <= WINDOW_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BKT_LIMIT:      bkt_limit_reg <= pwdata;
                REG_WINDOW_BUCKETS: window_reg    <= pwdata[WIN_W-1:0];
                default:            bkt_limit_reg <= bkt_limit_reg;
            endcase
        end
    end

    // derived values
    always_comb
    begin
        if (window_reg == '0)
            eff_n = WIN_W'(1);
        else if (window_reg > CAP_N)
            eff_n = CAP_N;
        else
            eff_n = window_reg;

        limit         = (bkt_limit_reg == '0) ? DATA_W'(1) : bkt_limit_reg;
        open_total    = {1'b0, open_buy_reg} + {1'b0, open_sell_reg};
        full_calc     = (filled_reg >= eff_n);
        slot_sum      = {1'b0, oldest_reg} + {1'b0, filled_reg};
        slot_wrap     = (slot_sum >= {1'b0, eff_n}) ? (slot_sum - {1'b0, eff_n}) : slot_sum;
        slot_calc     = full_calc ? oldest_reg : slot_wrap[WIN_W-1:0];
        slot_inc      = {1'b0, slot_reg} + 1'b1;
        qty_ext       = {1'b0, trade.qty};
        {rd_buy, rd_sell} = rd_data_reg;
        trade_acc     = trade_valid && trade_ready;
        out_free      = !result_valid_reg || result_ready;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        trade_ready = 1'b0;
        div_start   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                trade_ready = 1'b1;
                if (trade_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (open_total >= TOT_W'(limit))
                    state_next = S_EVICT;
                else
                    state_next = S_DIV_GO;
            end
            S_EVICT:    state_next = S_SUB;
            S_SUB:      state_next = S_ADD;
            S_ADD:      state_next = S_DIV_GO;
            S_DIV_GO:
            begin
                if (filled_reg != '0 && vol_sum_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // open bucket and window control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_buy_reg  <= '0;
            open_sell_reg <= '0;
            oldest_reg    <= '0;
            filled_reg    <= '0;
            abs_sum_reg   <= '0;
            vol_sum_reg   <= '0;
            closing_reg   <= 1'b0;
        end
        else if (cfg_wr && cfg_idx == REG_WINDOW_BUCKETS)
        begin
            oldest_reg  <= '0;
            filled_reg  <= '0;
            abs_sum_reg <= '0;
            vol_sum_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (trade_acc)
                    begin
                        if (trade.is_buy)
                            open_buy_reg <= open_buy_reg + qty_ext;
                        else
                            open_sell_reg <= open_sell_reg + qty_ext;
                    end
                end
                S_CHECK:
                begin
                    closing_reg <= (open_total >= TOT_W'(limit));
                end
                S_EVICT:
                begin
                    open_buy_reg  <= '0;
                    open_sell_reg <= '0;
                    if (full_reg)
                        oldest_reg <= (slot_inc == {1'b0, eff_n}) ? '0 : slot_inc[WIN_W-1:0];
                    else
                        filled_reg <= filled_reg + 1'b1;
                end
                S_SUB:
                begin
                    abs_sum_reg <= abs_sum_reg - SUM_W'(old_abs_reg);
                    vol_sum_reg <= vol_sum_reg - SUM_W'(old_tot_reg);
                end
                S_ADD:
                begin
                    abs_sum_reg <= abs_sum_reg + SUM_W'(new_abs_reg);
                    vol_sum_reg <= vol_sum_reg + SUM_W'(new_tot_reg);
                end
                default:
                begin
                    closing_reg <= closing_reg;
                end
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
        begin
            slot_reg <= slot_calc;
            full_reg <= full_calc;
        end
        if (state_reg == S_EVICT)
        begin
            old_abs_reg <= full_reg ? abs_diff(rd_buy, rd_sell) : '0;
            old_tot_reg <= full_reg ? ({1'b0, rd_buy} + {1'b0, rd_sell}) : '0;
            new_abs_reg <= abs_diff(open_buy_reg, open_sell_reg);
            new_tot_reg <= open_total;
        end
        if (state_reg == S_DIV_GO)
            vpin_reg <= '0;
        else if (state_reg == S_DIV_WAIT && div_done)
            vpin_reg <= div_quot;
    end

    // bucket ring
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHECK)
            rd_data_reg <= ring_mem[IDX_W'(slot_calc)];
        if (state_reg == S_EVICT)
            ring_mem[IDX_W'(slot_reg)] <= {open_buy_reg, open_sell_reg};
    end

    vpvbw_div #(
        .W (SUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (abs_sum_reg),
        .den   (vol_sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            result_reg.vpin_q16      <= vpin_reg;
            result_reg.bucket_closed <= closing_reg;
            result_reg.buckets_held  <= filled_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* hw/rtl/vpvbw_chk.sv */
// port checker for the volume bucket window top level and its bind
`default_nettype none

module vpvbw_chk
    import vpvbw_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    trade_valid,
    input wire logic    trade_ready,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire result_t result
);

    // one trade in flight: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        trade_valid && trade_ready |=> !trade_ready)
        else $error("trade taken while previous trade in work");

    a_vpin_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.vpin_q16 <= Q_ONE)
        else $error("vpin above one");

    a_closed_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.bucket_closed |-> result.buckets_held != '0)
        else $error("bucket closed with empty window");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

endmodule

bind vpin_volume_bucket_window_top vpvbw_chk u_vpvbw_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .trade_valid  (trade_valid),
    .trade_ready  (trade_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
